### hdl/dslc_pkg.sv
`default_nettype none
package dslc_pkg;

	localparam int DW    = 36;
	localparam int DVW   = 32;
	localparam int TAG_W = 115;

	localparam logic [2:0] REG_VERT_TOTAL = 3'd0;
	localparam logic [2:0] REG_HORZ_TOTAL = 3'd1;
	localparam logic [2:0] REG_PIX_CLK    = 3'd2;
	localparam logic [2:0] REG_INTERLACED = 3'd3;
	localparam logic [2:0] REG_MTU        = 3'd4;

	localparam logic [11:0] VT_RESET   = 12'd262;
	localparam logic [11:0] HT_RESET   = 12'd1560;
	localparam logic [18:0] PCLK_RESET = 19'd24576;
	localparam logic [13:0] MTU_RESET  = 14'd1472;

	localparam logic [31:0] WARMUP_FRAMES   = 32'd10;
	localparam logic [31:0] NS_PER_MS_KHZ   = 32'd1000000;
	localparam logic [35:0] SAFETY_NS       = 36'd2500000;
	localparam logic [30:0] PACKET_OVERHEAD = 31'd66;

	typedef struct packed {
		logic [11:0] v;
		logic        il;
		logic [23:0] payload;
		logic [31:0] stream;
		logic [31:0] rtt;
		logic [11:0] min_lines;
		logic        warm;
		logic        degen;
	} info_a_t;

	typedef struct packed {
		logic [11:0] v;
		logic [11:0] min_lines;
		logic        warm;
		logic        degen;
	} info_b_t;

	typedef struct packed {
		logic             vld;
		logic [DVW-1:0]   rem;
		logic [DW-1:0]    dq;
		logic [DVW-1:0]   dvs;
		logic [TAG_W-1:0] tag;
	} div_stage_t;

endpackage
`default_nettype wire

### hdl/delivery_sync_line_calc.sv
// sync_line and done leave s5; path: s1, line/pkt dividers, s2, s3, count divider, s4, s5.
// Throughput: one beat per cycle; busy stays low, so start may be held high every cycle.
// Each of the three dividers is 36 restoring stages, one quotient bit per stage.
// Reset clears the stage valid bits and loads the register defaults; no clearing pass.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`default_nettype none
module delivery_sync_line_calc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [23:0] payload_bytes,
	input  logic [31:0] last_frame_count,
	input  logic [31:0] last_stream_ns,
	input  logic [31:0] round_trip_ns,
	input  logic [11:0] minimum_lines,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [18:0] wr_data,
	output logic        done,
	output logic [11:0] sync_line
);
	import dslc_pkg::*;

	logic [11:0] vt_q, ht_q;
	logic [18:0] pclk_q;
	logic        il_q;
	logic [13:0] mtu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vt_q   <= VT_RESET;
			ht_q   <= HT_RESET;
			pclk_q <= PCLK_RESET;
			il_q   <= 1'b0;
			mtu_q  <= MTU_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_VERT_TOTAL: vt_q   <= wr_data[11:0];
				REG_HORZ_TOTAL: ht_q   <= wr_data[11:0];
				REG_PIX_CLK:    pclk_q <= wr_data;
				REG_INTERLACED: il_q   <= wr_data[0];
				REG_MTU:        mtu_q  <= wr_data[13:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic        vld_s1;
	info_a_t     info_s1;
	logic [31:0] line_dvd_s1;
	logic [18:0] khz_s1;
	logic [24:0] pkt_dvd_s1;
	logic [13:0] mtu_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		info_s1.v         <= vt_q;
		info_s1.il        <= il_q;
		info_s1.payload   <= payload_bytes;
		info_s1.stream    <= last_stream_ns;
		info_s1.rtt       <= round_trip_ns;
		info_s1.min_lines <= minimum_lines;
		info_s1.warm      <= last_frame_count < WARMUP_FRAMES;
		info_s1.degen     <= vt_q < 12'd2;
		line_dvd_s1       <= 32'(ht_q) * NS_PER_MS_KHZ;
		khz_s1            <= (pclk_q == '0) ? 19'd1 : pclk_q;
		mtu_s1            <= (mtu_q == '0) ? 14'd1 : mtu_q;
		pkt_dvd_s1        <= 25'(payload_bytes) + 25'((mtu_q == '0) ? 14'd1 : mtu_q) - 25'd1;
	end

	logic             line_vld;
	logic [DW-1:0]    line_q, pkt_q;
	logic [TAG_W-1:0] line_tag;

	dslc_div u_div_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.dividend (DW'(line_dvd_s1)),
		.divisor  (DVW'(khz_s1)),
		.tag_in   (TAG_W'(info_s1)),
		.out_vld  (line_vld),
		.quotient (line_q),
		.tag_out  (line_tag)
	);

	dslc_div u_div_pkt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.dividend (DW'(pkt_dvd_s1)),
		.divisor  (DVW'(mtu_s1)),
		.tag_in   ('0),
		.out_vld  (),
		.quotient (pkt_q),
		.tag_out  ()
	);

	info_a_t     ia;
	logic [31:0] cnt_c;
	assign ia = info_a_t'(line_tag);

	always_comb begin
		cnt_c = ia.il ? (line_q[31:0] >> 1) : line_q[31:0];
		if (cnt_c == '0) begin
			cnt_c = 32'd1;
		end
	end

	logic        vld_s2;
	info_a_t     info_s2;
	logic [31:0] cnt_s2;
	logic [33:0] wire_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= line_vld;
		end
	end

	always_ff @(posedge clk) begin
		info_s2 <= ia;
		cnt_s2  <= cnt_c;
		wire_s2 <= {31'(pkt_q[23:0]) * PACKET_OVERHEAD + 31'(ia.payload), 3'b000};
	end

	logic        vld_s3;
	info_b_t     infob_s3;
	logic [35:0] dvd_s3;
	logic [31:0] cnt_s3;
	logic [33:0] big_c;

	assign big_c = (34'(info_s2.stream) > wire_s2) ? 34'(info_s2.stream) : wire_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		infob_s3.v         <= info_s2.v;
		infob_s3.min_lines <= info_s2.min_lines;
		infob_s3.warm      <= info_s2.warm;
		infob_s3.degen     <= info_s2.degen;
		cnt_s3             <= cnt_s2;
		dvd_s3             <= 36'(big_c) + 36'(info_s2.rtt >> 1) + SAFETY_NS
			+ 36'(cnt_s2) - 36'd1;
	end

	logic             cnt_vld;
	logic [DW-1:0]    counts_q;
	logic [TAG_W-1:0] cnt_tag;

	dslc_div u_div_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.dividend (dvd_s3),
		.divisor  (cnt_s3),
		.tag_in   (TAG_W'(infob_s3)),
		.out_vld  (cnt_vld),
		.quotient (counts_q),
		.tag_out  (cnt_tag)
	);

	info_b_t     ib;
	logic [11:0] vm1_c, min_c, req_c;
	logic [35:0] max_c;

	assign ib    = info_b_t'(cnt_tag[$bits(info_b_t)-1:0]);
	assign vm1_c = ib.v - 12'd1;

	always_comb begin
		if (ib.min_lines == '0) begin
			min_c = ib.v >> 1;
		end else begin
			min_c = (ib.min_lines < vm1_c) ? ib.min_lines : vm1_c;
		end
		max_c = (counts_q > 36'(min_c)) ? counts_q : 36'(min_c);
		if (max_c == '0) begin
			max_c = 36'd1;
		end
		req_c = (max_c > 36'(vm1_c)) ? vm1_c : max_c[11:0];
	end

	logic        vld_s4;
	info_b_t     info_s4;
	logic [11:0] req_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= cnt_vld;
		end
	end

	always_ff @(posedge clk) begin
		info_s4 <= ib;
		req_s4  <= req_c;
	end

	logic        done_s5;
	logic [11:0] sync_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (info_s4.warm) begin
			sync_s5 <= info_s4.v >> 1;
		end else if (info_s4.degen) begin
			sync_s5 <= '0;
		end else begin
			sync_s5 <= info_s4.v - req_s4;
		end
	end

	assign done      = done_s5;
	assign sync_line = sync_s5;

endmodule
`default_nettype wire

### hdl/dslc_div.sv
`default_nettype none
module dslc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  logic [dslc_pkg::DW-1:0]    dividend,
	input  logic [dslc_pkg::DVW-1:0]   divisor,
	input  logic [dslc_pkg::TAG_W-1:0] tag_in,
	output logic                      out_vld,
	output logic [dslc_pkg::DW-1:0]    quotient,
	output logic [dslc_pkg::TAG_W-1:0] tag_out
);
	import dslc_pkg::*;

	function automatic div_stage_t div_step(input div_stage_t s);
		logic [DVW:0] trial;
		div_stage_t   n;
		n     = s;
		trial = {s.rem, s.dq[DW-1]};
		n.dq  = {s.dq[DW-2:0], 1'b0};
		if (trial >= {1'b0, s.dvs}) begin
			n.rem   = DVW'(trial - {1'b0, s.dvs});
			n.dq[0] = 1'b1;
		end else begin
			n.rem = trial[DVW-1:0];
		end
		return n;
	endfunction

	div_stage_t st_in;
	div_stage_t st [1:DW];

	always_comb begin
		st_in.vld = in_vld;
		st_in.rem = '0;
		st_in.dq  = dividend;
		st_in.dvs = divisor;
		st_in.tag = tag_in;
	end

	for (genvar k = 0; k < DW; k++) begin : g_stage
		div_stage_t prv;
		if (k == 0) begin : g_first
			assign prv = st_in;
		end else begin : g_next
			assign prv = st[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st[k+1].vld <= 1'b0;
			end else begin
				st[k+1] <= div_step(prv);
			end
		end
	end

	assign out_vld  = st[DW].vld;
	assign quotient = st[DW].dq;
	assign tag_out  = st[DW].tag;

endmodule
`default_nettype wire

### hdl/dslc_chk.sv
`default_nettype none
module dslc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [23:0] payload_bytes,
	input logic [31:0] last_frame_count,
	input logic [31:0] last_stream_ns,
	input logic [31:0] round_trip_ns,
	input logic [11:0] minimum_lines,
	input logic        wr_en,
	input logic [2:0]  wr_index,
	input logic [18:0] wr_data,
	input logic        done,
	input logic [11:0] sync_line
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline takes a beat every cycle");

	a_sync_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> sync_line != 12'hFFF)
		else $error("sync_line beyond the largest possible line");

	a_quiet_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !done)
		else $error("result strobe straight after reset");

endmodule

bind delivery_sync_line_calc dslc_chk u_chk (.*);
`default_nettype wire
